### sv/sfc_pkg.sv
// shared types and constants of the sphere frustum cull block
package sfc_pkg;

  // number of frustum planes
  localparam int NUM_PLANES = 6;

  // radius scale 1.3 as 333/256, times 4 to bring r into the Q.18 plane sum
  localparam logic [10:0] RADIUS_SCALE = 11'd1332;

  // register indexes on the config port
  localparam logic [2:0] REG_CAMERA_POSITION = 3'd0;
  localparam logic [2:0] REG_CAMERA_RADIUS   = 3'd1;
  localparam logic [2:0] REG_PLANE_0         = 3'd2;

  // cull reason codes
  typedef enum logic [1:0] {
    REASON_VISIBLE  = 2'd0,
    REASON_DISTANCE = 2'd1,
    REASON_PLANE    = 2'd2
  } reason_t;

  // one frustum plane as packed in its register
  typedef struct packed {
    logic [27:0] d;
    logic [11:0] nz;
    logic [11:0] ny;
    logic [11:0] nx;
  } plane_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [63:0]                  camera_position;
    logic [18:0]                  camera_radius;
    logic [NUM_PLANES-1:0][63:0]  planes;
  } cfg_t;

endpackage

### sv/sfc_regs.sv
// config register file on an apb-style port
module sfc_regs
  import sfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [2:0] idx;
  logic       wr;
  logic [2:0] plane_idx;

  assign pready    = 1'b1;
  assign idx       = paddr[5:3];
  assign wr        = psel && penable && pwrite;
  assign plane_idx = idx - REG_PLANE_0;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      priority if (idx == REG_CAMERA_POSITION) begin
        cfg.camera_position <= pwdata;
      end else if (idx == REG_CAMERA_RADIUS) begin
        cfg.camera_radius <= pwdata[18:0];
      end else begin
        cfg.planes[plane_idx] <= pwdata;
      end
    end
  end

  // register reads
  always_comb begin
    priority if (idx == REG_CAMERA_POSITION) begin
      prdata = cfg.camera_position;
    end else if (idx == REG_CAMERA_RADIUS) begin
      prdata = {45'd0, cfg.camera_radius};
    end else begin
      prdata = cfg.planes[plane_idx];
    end
  end

endmodule

### sv/sphere_frustum_cull.sv
// sphere visibility test against camera distance and six frustum planes
//
// One bounding sphere (center_x/y/z, object_radius) enters per beat on the
// item channel; one verdict (render_level, cull_reason, cull_plane) leaves per
// beat on the result channel. Each channel uses valid and stall; a beat moves
// when valid is high and stall is low.
// Camera position, camera radius and the six planes are written through the
// apb-style port; the user must write them only while the block is idle, as
// the block itself does not enforce it. Each item passes the input register,
// the product register and the result register in that order. Throughput:
// one item per cycle while the result channel does not stall; every product
// has its own multiplier, so nothing is shared between items.
// Reset clears all config registers and empties the pipeline; no clearing
// pass is needed. When the receiver stalls, the result register holds and
// earlier stages keep filling their empty slots; item_stall rises once every
// stage holds an item.
module sphere_frustum_cull
  import sfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  // item channel
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [19:0] center_x,
  input  logic signed [19:0] center_y,
  input  logic signed [19:0] center_z,
  input  logic [18:0]        object_radius,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic               render_level,
  output logic [1:0]         cull_reason,
  output logic [2:0]         cull_plane
);

  cfg_t cfg;

  sfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage flow control
  logic v1, v2;
  logic adv1, adv2, adv3;

  assign adv3       = !result_valid || !result_stall;
  assign adv2       = !v2 || adv3;
  assign adv1       = !v1 || adv2;
  assign item_stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= item_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        result_valid <= v2;
      end
    end
  end

  // input register
  logic signed [19:0] cx1, cy1, cz1;
  logic [18:0]        r1;

  always_ff @(posedge clk) begin
    if (adv1) begin
      cx1 <= center_x;
      cy1 <= center_y;
      cz1 <= center_z;
      r1  <= object_radius;
    end
  end

  // stage 2: differences, squares, radius terms and plane products
  logic signed [19:0] kx, ky, kz;
  logic signed [20:0] dx, dy, dz;
  logic signed [41:0] sqx, sqy, sqz;
  logic [19:0]        rs;
  logic [39:0]        rs2;
  logic [29:0]        rk;
  logic signed [31:0] px [NUM_PLANES];
  logic signed [31:0] py [NUM_PLANES];
  logic signed [31:0] pz [NUM_PLANES];

  always_comb begin
    plane_t p;
    kx  = cfg.camera_position[19:0];
    ky  = cfg.camera_position[39:20];
    kz  = cfg.camera_position[59:40];
    dx  = 21'(cx1) - 21'(kx);
    dy  = 21'(cy1) - 21'(ky);
    dz  = 21'(cz1) - 21'(kz);
    sqx = dx * dx;
    sqy = dy * dy;
    sqz = dz * dz;
    rs  = 20'(r1) + 20'(cfg.camera_radius);
    rs2 = rs * rs;
    rk  = 30'(r1) * 30'(RADIUS_SCALE);
    for (int i = 0; i < NUM_PLANES; i++) begin
      p     = plane_t'(cfg.planes[i]);
      px[i] = 32'($signed(p.nx)) * 32'(cx1);
      py[i] = 32'($signed(p.ny)) * 32'(cy1);
      pz[i] = 32'($signed(p.nz)) * 32'(cz1);
    end
  end

  logic [40:0]        sqx2, sqy2, sqz2;
  logic [39:0]        rs2_2;
  logic [29:0]        rk2;
  logic signed [31:0] px2 [NUM_PLANES];
  logic signed [31:0] py2 [NUM_PLANES];
  logic signed [31:0] pz2 [NUM_PLANES];

  always_ff @(posedge clk) begin
    if (adv2) begin
      sqx2  <= sqx[40:0];
      sqy2  <= sqy[40:0];
      sqz2  <= sqz[40:0];
      rs2_2 <= rs2;
      rk2   <= rk;
      px2   <= px;
      py2   <= py;
      pz2   <= pz;
    end
  end

  // stage 3: distance compare, plane sums and first culling plane
  logic [42:0]            dist2;
  logic                   far;
  logic signed [39:0]     h [NUM_PLANES];
  logic [NUM_PLANES-1:0]  hit;
  logic [2:0]             first_hit;
  logic                   level_next;
  reason_t                reason_next;
  logic [2:0]             plane_next;

  always_comb begin
    plane_t p;
    dist2 = 43'(sqx2) + 43'(sqy2) + 43'(sqz2);
    far   = dist2 > 43'(rs2_2);
    for (int i = 0; i < NUM_PLANES; i++) begin
      p      = plane_t'(cfg.planes[i]);
      h[i]   = 40'(px2[i]) + 40'(py2[i]) + 40'(pz2[i])
             + $signed({{2{p.d[27]}}, p.d, 10'd0})
             - $signed({10'd0, rk2});
      hit[i] = !h[i][39];
    end
    // lowest index wins
    first_hit = '0;
    for (int i = NUM_PLANES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        first_hit = 3'(i);
      end
    end
    priority if (far) begin
      level_next  = 1'b0;
      reason_next = REASON_DISTANCE;
      plane_next  = '0;
    end else if (|hit) begin
      level_next  = 1'b0;
      reason_next = REASON_PLANE;
      plane_next  = first_hit;
    end else begin
      level_next  = 1'b1;
      reason_next = REASON_VISIBLE;
      plane_next  = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv3) begin
      render_level <= level_next;
      cull_reason  <= reason_next;
      cull_plane   <= plane_next;
    end
  end

  // checks
  a_visible_renders: assert property (@(posedge clk) disable iff (rst)
    result_valid && (cull_reason == REASON_VISIBLE) |-> render_level)
    else $error("visible result without render");

  a_culled_has_reason: assert property (@(posedge clk) disable iff (rst)
    result_valid && !render_level |->
      (cull_reason == REASON_DISTANCE) || (cull_reason == REASON_PLANE))
    else $error("culled result without a reason");

  a_plane_only_on_plane_cull: assert property (@(posedge clk) disable iff (rst)
    result_valid && (cull_reason != REASON_PLANE) |-> cull_plane == 3'd0)
    else $error("plane index set without plane cull");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> v1 && v2 && result_valid && result_stall)
    else $error("item stall with a free stage");

endmodule
